[sv/rwcs_pkg.sv]
// Shared types, codes and default sizes for the wall column span block.
package rwcs_pkg;

  localparam int SCREEN_HEIGHT_DEF   = 512;
  localparam int SCREEN_WIDTH_DEF    = 1024;
  localparam int COS_TABLE_DEPTH_DEF = 1024;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ATT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EAST_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEST_COLOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_COLOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_COLOR  = 3'd5;

  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_NORTH = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  typedef struct packed {
    logic [9:0]  column;
    logic [15:0] ray_angle;
    logic [31:0] ray_distance;
    logic [31:0] hit_x;
    logic [31:0] hit_y;
  } in_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [9:0]  first_row;
    logic [9:0]  end_row;
    logic [1:0]  wall_face;
    logic [23:0] wall_color;
  } out_t;

  // Classified ray handed from the front end to the span unit.
  typedef struct packed {
    logic [9:0]         column;
    logic [31:0]        distance;
    logic signed [17:0] cos_q16;
    logic [1:0]         face;
    logic [23:0]        color;
    logic               col_ok;
  } ray_t;

endpackage

[sv/rwcs_front.sv]
// Front end: angle difference, cosine ROM lookup and wall face selection.
module rwcs_front #(
  parameter int ScreenWidth = rwcs_pkg::SCREEN_WIDTH_DEF,
  parameter int CosDepth    = rwcs_pkg::COS_TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  rwcs_pkg::in_t   in_data,
  input  logic [15:0]     player_angle,
  input  logic [23:0]     east_color,
  input  logic [23:0]     west_color,
  input  logic [23:0]     north_color,
  input  logic [23:0]     south_color,
  output logic            ray_valid,
  output rwcs_pkg::ray_t  ray
);
  import rwcs_pkg::*;

  localparam int KW = $clog2(CosDepth);
  localparam int PW = 16 + KW + 1;
  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  typedef logic signed [17:0] rom_t [CosDepth];

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / Q30_ONE;
  endfunction

  function automatic longint q30_series(longint x, logic is_sin);
    longint x2;
    longint h;
    longint m;
    x2 = q30_mul(x, x);
    h = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      m = q30_mul(x2, h);
      unique case (i)
        0: h = Q30_ONE - (is_sin ? m / 156 : m / 132);
        1: h = Q30_ONE - (is_sin ? m / 110 : m / 90);
        2: h = Q30_ONE - (is_sin ? m / 72 : m / 56);
        3: h = Q30_ONE - (is_sin ? m / 42 : m / 30);
        4: h = Q30_ONE - (is_sin ? m / 20 : m / 12);
        default: h = Q30_ONE - (is_sin ? m / 6 : m / 2);
      endcase
    end
    return is_sin ? q30_mul(x, h) : h;
  endfunction

  function automatic longint q30_to_q16(longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > Q30_ONE) c = Q30_ONE;
    return (c + 8192) >>> 14;
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    longint t;
    longint r;
    longint x;
    longint v;
    for (int k = 0; k < CosDepth; k++) begin
      t = (longint'(k) <<< 32) / CosDepth;
      r = t & ((64'sd1 <<< 30) - 1);
      x = (r * TWO_PI_Q30) >>> 32;
      unique case ((t >>> 30) & 3)
        0: v = q30_to_q16(q30_series(x, 1'b0));
        1: v = -q30_to_q16(q30_series(x, 1'b1));
        2: v = -q30_to_q16(q30_series(x, 1'b0));
        default: v = q30_to_q16(q30_series(x, 1'b1));
      endcase
      rom[k] = 18'(v);
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  logic [15:0]   diff;
  logic [PW-1:0] kprod;
  logic [KW-1:0] k;
  logic          grid_x;
  logic          grid_y;
  logic [1:0]    face;
  logic [23:0]   color;
  logic          valid_r;
  ray_t          ray_r;

  assign diff   = player_angle - in_data.ray_angle;
  assign kprod  = PW'(diff) * PW'(CosDepth);
  assign k      = kprod[16 +: KW];
  assign grid_x = (in_data.hit_x[15:0] == 16'h0000) || (in_data.hit_x[15:0] == 16'hFFFF);
  assign grid_y = (in_data.hit_y[15:0] == 16'h0000) || (in_data.hit_y[15:0] == 16'hFFFF);

  always_comb begin
    if (grid_x && !grid_y) begin
      face = (in_data.ray_angle > 16'd16384 && in_data.ray_angle < 16'd49152)
             ? FACE_EAST : FACE_WEST;
    end else begin
      face = (in_data.ray_angle > 16'd32768) ? FACE_NORTH : FACE_SOUTH;
    end
    unique case (face)
      FACE_EAST:  color = east_color;
      FACE_WEST:  color = west_color;
      FACE_NORTH: color = north_color;
      default:    color = south_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    ray_r.column   <= in_data.column;
    ray_r.distance <= in_data.ray_distance;
    ray_r.cos_q16  <= COS_ROM[k];
    ray_r.face     <= face;
    ray_r.color    <= color;
    ray_r.col_ok   <= {22'd0, in_data.column} < 32'(ScreenWidth);
  end

  assign ray_valid = valid_r;
  assign ray       = ray_r;
endmodule

[sv/rwcs_fifo.sv]
// Two-entry queue between the front end and the span unit.
module rwcs_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rwcs_pkg::ray_t  push_data,
  input  logic            pop,
  output logic            not_empty,
  output rwcs_pkg::ray_t  pop_data
);
  import rwcs_pkg::*;

  ray_t       mem_r [2];
  logic       wr_r;
  logic       wr_nxt;
  logic       rd_r;
  logic       rd_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_pop;
  logic       do_push;

  assign do_pop  = pop && (cnt_r != 2'd0);
  assign do_push = push && (cnt_r != 2'd2);

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign not_empty = cnt_r != 2'd0;
  assign pop_data  = mem_r[rd_r];
endmodule

[sv/rwcs_back.sv]
// Span unit: fish-eye correction, attenuation multiply, pipelined divide and span.
module rwcs_back #(
  parameter int ScreenHeight = rwcs_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ray_valid,
  input  rwcs_pkg::ray_t  ray,
  input  logic [31:0]     height_att,
  output logic            out_valid,
  output rwcs_pkg::out_t  out_data
);
  import rwcs_pkg::*;

  localparam int QW = $clog2(ScreenHeight) + 1;
  localparam int DW = 33 + $clog2(ScreenHeight) + 1 + 64 - 32 + QW;
  localparam logic [DW-1:0] NUMER = DW'(ScreenHeight) << 32;

  typedef struct packed {
    logic [9:0]  column;
    logic [1:0]  face;
    logic [23:0] color;
    logic        col_ok;
  } tag_t;

  typedef struct packed {
    tag_t          tag;
    logic          empty;
    logic          full;
    logic [DW-1:0] rem;
    logic [DW-1:0] div;
    logic [QW-1:0] quo;
  } dstage_t;

  logic               v1_r, v2_r, v3_r;
  tag_t               t1_r, t2_r, t3_r;
  logic signed [50:0] prod_r;
  logic signed [50:0] prod_adj;
  logic signed [34:0] d_full;
  logic               neg_r;
  logic [31:0]        dpos_r;
  logic               neg3_r;
  logic [63:0]        p_r;

  assign prod_adj = prod_r + (prod_r[50] ? 51'sd65535 : 51'sd0);
  assign d_full   = 35'(prod_adj >>> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ray_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r   <= '{column: ray.column, face: ray.face, color: ray.color, col_ok: ray.col_ok};
    prod_r <= $signed({19'd0, ray.distance}) * 51'(ray.cos_q16);
    t2_r   <= t1_r;
    neg_r  <= d_full < 0;
    dpos_r <= d_full[31:0];
    t3_r   <= t2_r;
    neg3_r <= neg_r;
    p_r    <= 64'(dpos_r) * 64'(height_att);
  end

  // Restoring divide, one quotient bit per stage; a quotient of 2^QW or more is flagged full.
  logic    dv_r [QW+1];
  dstage_t ds_r [QW+1];
  dstage_t ds_nxt [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QW; j++) dv_r[j] <= 1'b0;
    end else begin
      dv_r[0] <= v3_r;
      for (int j = 0; j < QW; j++) dv_r[j+1] <= dv_r[j];
    end
  end

  always_comb begin
    logic [DW-1:0] sh;
    logic          ge;
    sh = '0;
    ge = 1'b0;
    ds_nxt[0].tag   = t3_r;
    ds_nxt[0].empty = neg3_r || !t3_r.col_ok;
    ds_nxt[0].full  = (p_r == 64'd0) || (NUMER >= (DW'(p_r) << QW));
    ds_nxt[0].rem   = NUMER;
    ds_nxt[0].div   = DW'(p_r);
    ds_nxt[0].quo   = '0;
    for (int j = 0; j < QW; j++) begin
      sh = ds_r[j].div << (QW - 1 - j);
      ge = ds_r[j].rem >= sh;
      ds_nxt[j+1] = ds_r[j];
      ds_nxt[j+1].rem = ge ? ds_r[j].rem - sh : ds_r[j].rem;
      ds_nxt[j+1].quo[QW-1-j] = ge;
    end
  end

  always_ff @(posedge clk) begin
    ds_r <= ds_nxt;
  end

  dstage_t     last;
  logic [31:0] h32;
  logic [31:0] first32;
  logic [31:0] end32;
  logic        out_valid_r;
  out_t        out_r;

  assign last = ds_r[QW];
  assign h32  = 32'(last.quo);

  always_comb begin
    if (last.empty) begin
      first32 = 32'd0;
      end32   = 32'd0;
    end else if (last.full || h32 >= 32'(ScreenHeight)) begin
      first32 = 32'd0;
      end32   = 32'(ScreenHeight);
    end else begin
      first32 = (32'(ScreenHeight) - h32) >> 1;
      end32   = first32 + h32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_r.out_column <= last.tag.column;
    out_r.first_row  <= first32[9:0];
    out_r.end_row    <= end32[9:0];
    out_r.wall_face  <= last.tag.face;
    out_r.wall_color <= last.tag.color;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

[sv/raycast_wall_column_span.sv]
// Top level of the wall column span block: configuration, front end, queue and span unit.
// Usage:
// Pulse start with a ray on in_data; a transaction is taken at each edge where start is
// high and busy is low. busy stays low, so one ray can be accepted every cycle.
// Each ray gives exactly one result on out_data, marked by out_valid for one cycle.
// The receiver cannot hold results off; it must take each one as it appears.
// From acceptance to out_valid a ray passes the cosine ROM read, the queue, two
// multiplies and the restoring divider, which produces one quotient bit per
// pipeline stage.
// Throughput is one ray per cycle.
// Configuration goes through cfg_we, cfg_index and cfg_wdata: index 0 player angle,
// 1 height attenuation, 2 to 5 the east, west, north and south colors.
// Write configuration only while no ray is in flight.
// Synchronous reset clears all valid flags and sets the attenuation to 1.0 and the
// angle and colors to zero; results in flight at reset are dropped.
module raycast_wall_column_span #(
  parameter int ScreenHeight = rwcs_pkg::SCREEN_HEIGHT_DEF,
  parameter int ScreenWidth  = rwcs_pkg::SCREEN_WIDTH_DEF,
  parameter int CosDepth     = rwcs_pkg::COS_TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  rwcs_pkg::in_t                       in_data,
  output logic                                out_valid,
  output rwcs_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [rwcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rwcs_pkg::*;

  logic [15:0] player_angle_r;
  logic [31:0] height_att_r;
  logic [23:0] east_color_r;
  logic [23:0] west_color_r;
  logic [23:0] north_color_r;
  logic [23:0] south_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_angle_r <= 16'd0;
      height_att_r   <= 32'd65536;
      east_color_r   <= 24'd0;
      west_color_r   <= 24'd0;
      north_color_r  <= 24'd0;
      south_color_r  <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAYER_ANGLE: player_angle_r <= cfg_wdata[15:0];
        REG_HEIGHT_ATT:   height_att_r   <= cfg_wdata;
        REG_EAST_COLOR:   east_color_r   <= cfg_wdata[23:0];
        REG_WEST_COLOR:   west_color_r   <= cfg_wdata[23:0];
        REG_NORTH_COLOR:  north_color_r  <= cfg_wdata[23:0];
        REG_SOUTH_COLOR:  south_color_r  <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  logic acc;
  logic f_valid;
  ray_t f_ray;
  logic q_valid;
  ray_t q_ray;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  rwcs_front #(
    .ScreenWidth (ScreenWidth),
    .CosDepth    (CosDepth)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .in_data      (in_data),
    .player_angle (player_angle_r),
    .east_color   (east_color_r),
    .west_color   (west_color_r),
    .north_color  (north_color_r),
    .south_color  (south_color_r),
    .ray_valid    (f_valid),
    .ray          (f_ray)
  );

  // The span unit never stalls, so the queue drains every cycle.
  rwcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (f_ray),
    .pop       (1'b1),
    .not_empty (q_valid),
    .pop_data  (q_ray)
  );

  rwcs_back #(
    .ScreenHeight (ScreenHeight)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ray_valid  (q_valid),
    .ray        (q_ray),
    .height_att (height_att_r),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_east_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wall_face == FACE_EAST |-> out_data.wall_color == east_color_r)
    else $error("east face carries wrong color");

  a_south_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wall_face == FACE_SOUTH |-> out_data.wall_color == south_color_r)
    else $error("south face carries wrong color");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ScreenHeight < 1024 |-> out_data.first_row <= out_data.end_row)
    else $error("span ends before it starts");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");
`endif
endmodule

[sim/tb_raycast_wall_column_span.sv]
// Self-checking testbench for the wall column span block, driven by directed rays and random rays.
module tb_raycast_wall_column_span;
  import rwcs_pkg::*;

  localparam int SCR_H = SCREEN_HEIGHT_DEF;
  localparam int SCR_W = SCREEN_WIDTH_DEF;
  localparam int COS_N = COS_TABLE_DEPTH_DEF;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the block's registers and its cosine ROM.
  logic [15:0] view_angle;
  logic [31:0] att_q16;
  logic [23:0] face_rgb [4];
  logic signed [31:0] cos_q16 [COS_N];

  out_t span_q[$];
  int err_count;

  typedef struct {
    in_t  ray;
    bit   typed;
    out_t span;
  } ray_row_t;

  raycast_wall_column_span dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / Q30;
  endfunction

  function automatic longint series_cos(longint x);
    longint divs [6] = '{132, 90, 56, 30, 12, 2};
    longint x2;
    longint h;
    x2 = q30_mul(x, x);
    h = Q30;
    for (int i = 0; i < 6; i++) h = Q30 - q30_mul(x2, h) / divs[i];
    return h;
  endfunction

  function automatic longint series_sin(longint x);
    longint divs [6] = '{156, 110, 72, 42, 20, 6};
    longint x2;
    longint h;
    x2 = q30_mul(x, x);
    h = Q30;
    for (int i = 0; i < 6; i++) h = Q30 - q30_mul(x2, h) / divs[i];
    return q30_mul(x, h);
  endfunction

  function automatic int to_q16(longint v);
    if (v < 0) v = 0;
    if (v > Q30) v = Q30;
    return int'((v + 8192) >>> 14);
  endfunction

  function automatic void build_cos_rom();
    longint unsigned t;
    longint unsigned r;
    longint x;
    for (int k = 0; k < COS_N; k++) begin
      t = (longint'(k) << 32) / COS_N;
      r = t & ((64'd1 << 30) - 1);
      x = longint'((r * TWO_PI_Q30) >> 32);
      case ((t >> 30) & 3)
        0: cos_q16[k] = to_q16(series_cos(x));
        1: cos_q16[k] = -to_q16(series_sin(x));
        2: cos_q16[k] = -to_q16(series_cos(x));
        default: cos_q16[k] = to_q16(series_sin(x));
      endcase
    end
  endfunction

  function automatic bit on_grid(logic [31:0] c);
    return c[15:0] == 16'h0000 || c[15:0] == 16'hFFFF;
  endfunction

  function automatic out_t predict_span(in_t r);
    out_t o;
    logic [15:0] diff;
    longint d;
    longint unsigned p;
    longint unsigned h;
    longint first;
    longint last;
    diff = view_angle - r.ray_angle;
    d = (longint'({32'd0, r.ray_distance}) * longint'(cos_q16[(diff * COS_N) >> 16])) / 65536;
    first = 0;
    last = 0;
    if (r.column < SCR_W && d >= 0) begin
      p = longint'(unsigned'(d)) * {32'd0, att_q16};
      h = SCR_H;
      if (p != 0) h = (longint'(SCR_H) << 32) / p;
      if (h >= SCR_H) begin
        last = SCR_H;
      end else begin
        first = (SCR_H - longint'(h)) / 2;
        last = first + longint'(h);
      end
    end
    if (on_grid(r.hit_x) && !on_grid(r.hit_y))
      o.wall_face = (r.ray_angle > 16384 && r.ray_angle < 49152) ? FACE_EAST : FACE_WEST;
    else
      o.wall_face = (r.ray_angle > 32768) ? FACE_NORTH : FACE_SOUTH;
    o.out_column = r.column;
    o.first_row = first[9:0];
    o.end_row = last[9:0];
    o.wall_color = face_rgb[o.wall_face];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (span_q.size() == 0) begin
        report_mismatch("unexpected result", out_data, 0);
      end else begin
        want = span_q.pop_front();
        if (out_data.out_column !== want.out_column)
          report_mismatch("out_column", out_data.out_column, want.out_column);
        if (out_data.first_row !== want.first_row)
          report_mismatch("first_row", out_data.first_row, want.first_row);
        if (out_data.end_row !== want.end_row)
          report_mismatch("end_row", out_data.end_row, want.end_row);
        if (out_data.wall_face !== want.wall_face)
          report_mismatch("wall_face", out_data.wall_face, want.wall_face);
        if (out_data.wall_color !== want.wall_color)
          report_mismatch("wall_color", out_data.wall_color, want.wall_color);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PLAYER_ANGLE: view_angle = val[15:0];
      REG_HEIGHT_ATT:   att_q16 = val;
      REG_EAST_COLOR:   face_rgb[FACE_EAST] = val[23:0];
      REG_WEST_COLOR:   face_rgb[FACE_WEST] = val[23:0];
      REG_NORTH_COLOR:  face_rgb[FACE_NORTH] = val[23:0];
      default:          face_rgb[FACE_SOUTH] = val[23:0];
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= $urandom;
  endtask

  task automatic send_ray(in_t r, bit typed, out_t span);
    @(negedge clk);
    start <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    span_q.push_back(typed ? span : predict_span(r));
  endtask

  task automatic pause_input(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= $bits(in_t)'({$urandom, $urandom, $urandom, $urandom});
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic settle();
    pause_input(1);
    wait (span_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 3))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      default: ;
    endcase
    return c;
  endfunction

  function automatic in_t rand_ray();
    in_t r;
    r.column = 10'($urandom);
    r.ray_angle = ($urandom_range(0, 3) == 0) ?
                  16'(view_angle + $urandom_range(0, 6) * 16384 + $urandom_range(0, 2) - 1) :
                  16'($urandom);
    r.ray_distance = $urandom >> $urandom_range(0, 31);
    r.hit_x = rand_coord();
    r.hit_y = rand_coord();
    return r;
  endfunction

  initial begin
    ray_row_t rows [$];
    out_t none;
    int bursts;
    none = '0;
    err_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PLAYER_ANGLE;
    cfg_wdata = '0;
    build_cos_rom();
    view_angle = 16'd0;
    att_q16 = 32'd65536;
    for (int i = 0; i < 4; i++) face_rgb[i] = 24'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: unit attenuation, heading zero, all colors black.
    rows.push_back('{'{10'd0, 16'd0, 32'd0, 32'd0, 32'd0}, 1,
                     '{10'd0, 10'd0, 10'd512, FACE_SOUTH, 24'd0}});
    rows.push_back('{'{10'd1023, 16'd32768, 32'h0001_0000, 32'h8000, 32'h8000}, 1,
                     '{10'd1023, 10'd0, 10'd0, FACE_SOUTH, 24'd0}});
    rows.push_back('{'{10'd5, 16'd0, 32'd1, 32'h0001_0000, 32'd0}, 1,
                     '{10'd5, 10'd0, 10'd512, FACE_SOUTH, 24'd0}});
    rows.push_back('{'{10'd7, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678}, 0, none});
    rows.push_back('{'{10'd8, 16'd16384, 32'h0004_0000, 32'h0003_0000, 32'h0001_0001}, 0, none});
    rows.push_back('{'{10'd9, 16'd16385, 32'h0004_0000, 32'h0003_FFFF, 32'h0001_8000}, 0, none});
    rows.push_back('{'{10'd10, 16'd49151, 32'h0002_8000, 32'h0000_0000, 32'h0000_0001}, 0, none});
    rows.push_back('{'{10'd11, 16'd49152, 32'h0002_8000, 32'h0000_FFFF, 32'h0000_FFFE}, 0, none});
    rows.push_back('{'{10'd12, 16'd32769, 32'h0010_0000, 32'h0000_1234, 32'h0000_0000}, 0, none});
    rows.push_back('{'{10'd13, 16'd65535, 32'h0001_0001, 32'hFFFF_0000, 32'hFFFF_FFFF}, 0, none});
    rows.push_back('{'{10'd14, 16'd32767, 32'h0200_0000, 32'h0000_0001, 32'h0000_0002}, 0, none});
    rows.push_back('{'{10'd15, 16'd8192, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555}, 0, none});
    foreach (rows[i]) begin
      send_ray(rows[i].ray, rows[i].typed, rows[i].span);
      pause_input(gap_len());
    end
    settle();

    // Each setting is followed by a burst of random rays; the first two settings hit the extremes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_PLAYER_ANGLE, 32'hFFFF_FFFF);
          write_reg(REG_HEIGHT_ATT, 32'hFFFF_FFFF);
          for (int i = 0; i < 4; i++)
            write_reg(CFG_IDX_W'(REG_EAST_COLOR + i), 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_PLAYER_ANGLE, 32'd0);
          write_reg(REG_HEIGHT_ATT, 32'd1);
          for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(REG_EAST_COLOR + i), 32'd0);
        end
        2: write_reg(REG_HEIGHT_ATT, 32'd65536);
        default: begin
          write_reg(REG_PLAYER_ANGLE, $urandom);
          write_reg(REG_HEIGHT_ATT, ($urandom >> $urandom_range(0, 24)) | 32'd1);
          for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(REG_EAST_COLOR + i), $urandom);
        end
      endcase
      end_writes();
      bursts = 250;
      for (int n = 0; n < bursts; n++) begin
        send_ray(rand_ray(), 0, none);
        if ($urandom_range(0, 9) != 0) pause_input(gap_len());
      end
      settle();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/rwcs_pkg.sv
sv/rwcs_front.sv
sv/rwcs_fifo.sv
sv/rwcs_back.sv
sv/raycast_wall_column_span.sv
sim/tb_raycast_wall_column_span.sv
